// File: rtl/core/h2r_pkg.sv
// Shared types and constants for the HSV to RGBA conversion pipeline.
`default_nettype none

package h2r_pkg;

   localparam int unsigned CHAN_W   = 17;   // Q1.16 channel width
   localparam int unsigned HUE_W    = 16;   // hue, fraction of a turn
   localparam int unsigned FRAC_W   = 16;   // in-sector fraction
   localparam int unsigned SECTOR_W = 3;
   localparam int unsigned PROD_W   = 2 * CHAN_W;

   localparam logic [CHAN_W-1:0] ONE_Q16 = 17'h10000;

   // Hue sectors, sixty degrees each
   localparam logic [SECTOR_W-1:0] SECTOR_RED_YELLOW    = 3'd0;
   localparam logic [SECTOR_W-1:0] SECTOR_YELLOW_GREEN  = 3'd1;
   localparam logic [SECTOR_W-1:0] SECTOR_GREEN_CYAN    = 3'd2;
   localparam logic [SECTOR_W-1:0] SECTOR_CYAN_BLUE     = 3'd3;
   localparam logic [SECTOR_W-1:0] SECTOR_BLUE_MAGENTA  = 3'd4;

   typedef logic [CHAN_W-1:0] chan_type;

   // After clamping and sector split
   typedef struct packed {
      logic [SECTOR_W-1:0] sector;
      logic [FRAC_W-1:0]   frac;
      chan_type            sat;
      chan_type            val;
      chan_type            alpha;
   } prep_type;

   // After the first multiplier rank
   typedef struct packed {
      logic [SECTOR_W-1:0] sector;
      chan_type            val;
      chan_type            alpha;
      chan_type            sf;
      chan_type            sf1;
      chan_type            p;
   } mult_type;

   // All levels available
   typedef struct packed {
      logic [SECTOR_W-1:0] sector;
      chan_type            val;
      chan_type            alpha;
      chan_type            p;
      chan_type            q;
      chan_type            t;
   } level_type;

   typedef struct packed {
      chan_type alpha;
      chan_type blue;
      chan_type green;
      chan_type red;
   } rgba_type;

   // Truncating Q1.16 scale: (a * b) >> 16, result known to fit 17 bits
   function automatic chan_type scale_q16(chan_type a, chan_type b);
      logic [PROD_W-1:0] prod;
      prod = PROD_W'(a) * PROD_W'(b);
      return prod[FRAC_W +: CHAN_W];
   endfunction

endpackage

`default_nettype wire

// File: rtl/core/h2r_prep.sv
// Stage 1: clamp saturation and value, split hue into sector and fraction.
`default_nettype none

module h2r_prep (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       valid_in,
   output logic                            ready_out,
   input  wire logic [h2r_pkg::HUE_W-1:0]  hue,
   input  wire h2r_pkg::chan_type          saturation,
   input  wire h2r_pkg::chan_type          brightness,
   input  wire h2r_pkg::chan_type          alpha_in,
   output logic                            valid_out,
   input  wire logic                       ready_in,
   output h2r_pkg::prep_type               data_out
);
   import h2r_pkg::*;

   localparam int unsigned H6_W = HUE_W + SECTOR_W;

   logic              valid_ff;
   prep_type          data_ff;
   prep_type          data_in;
   logic [H6_W-1:0]   hue_x6;

   // hue * 6 as (4h + 2h)
   assign hue_x6 = (H6_W'(hue) << 2) + (H6_W'(hue) << 1);

   always_comb begin
      data_in.sector = hue_x6[H6_W-1 -: SECTOR_W];
      data_in.frac   = hue_x6[FRAC_W-1:0];
      data_in.sat    = (saturation > ONE_Q16) ? ONE_Q16 : saturation;
      data_in.val    = (brightness > ONE_Q16) ? ONE_Q16 : brightness;
      data_in.alpha  = alpha_in;
   end

   assign ready_out = !valid_ff || ready_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ready_out) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ready_out && valid_in) begin
         data_ff <= data_in;
      end
   end

   assign valid_out = valid_ff;
   assign data_out  = data_ff;

endmodule

`default_nettype wire

// File: rtl/core/h2r_mult.sv
// Stage 2: s*f, s*(1-f) and p = v*(1-s), three parallel multipliers.
`default_nettype none

module h2r_mult (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              valid_in,
   output logic                   ready_out,
   input  wire h2r_pkg::prep_type data_in_stage,
   output logic                   valid_out,
   input  wire logic              ready_in,
   output h2r_pkg::mult_type      data_out
);
   import h2r_pkg::*;

   logic     valid_ff;
   mult_type data_ff;
   mult_type data_in;
   chan_type frac_ext;

   assign frac_ext = CHAN_W'(data_in_stage.frac);

   always_comb begin
      data_in.sector = data_in_stage.sector;
      data_in.val    = data_in_stage.val;
      data_in.alpha  = data_in_stage.alpha;
      data_in.sf     = scale_q16(data_in_stage.sat, frac_ext);
      data_in.sf1    = scale_q16(data_in_stage.sat, ONE_Q16 - frac_ext);
      data_in.p      = scale_q16(data_in_stage.val, ONE_Q16 - data_in_stage.sat);
   end

   assign ready_out = !valid_ff || ready_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ready_out) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ready_out && valid_in) begin
         data_ff <= data_in;
      end
   end

   assign valid_out = valid_ff;
   assign data_out  = data_ff;

endmodule

`default_nettype wire

// File: rtl/core/h2r_level.sv
// Stage 3: q = v*(1-sf) and t = v*(1-sf1).
`default_nettype none

module h2r_level (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              valid_in,
   output logic                   ready_out,
   input  wire h2r_pkg::mult_type data_in_stage,
   output logic                   valid_out,
   input  wire logic              ready_in,
   output h2r_pkg::level_type     data_out
);
   import h2r_pkg::*;

   logic      valid_ff;
   level_type data_ff;
   level_type data_in;

   always_comb begin
      data_in.sector = data_in_stage.sector;
      data_in.val    = data_in_stage.val;
      data_in.alpha  = data_in_stage.alpha;
      data_in.p      = data_in_stage.p;
      data_in.q      = scale_q16(data_in_stage.val, ONE_Q16 - data_in_stage.sf);
      data_in.t      = scale_q16(data_in_stage.val, ONE_Q16 - data_in_stage.sf1);
   end

   assign ready_out = !valid_ff || ready_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ready_out) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ready_out && valid_in) begin
         data_ff <= data_in;
      end
   end

   assign valid_out = valid_ff;
   assign data_out  = data_ff;

endmodule

`default_nettype wire

// File: rtl/core/h2r_mux.sv
// Stage 4: route v, p, q, t onto red, green, blue by sector; output register.
`default_nettype none

module h2r_mux (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               valid_in,
   output logic                    ready_out,
   input  wire h2r_pkg::level_type data_in_stage,
   output logic                    valid_out,
   input  wire logic               ready_in,
   output h2r_pkg::rgba_type       data_out
);
   import h2r_pkg::*;

   logic     valid_ff;
   rgba_type data_ff;
   rgba_type data_in;

   always_comb begin
      data_in.alpha = data_in_stage.alpha;
      unique case (data_in_stage.sector)
         SECTOR_RED_YELLOW: begin
            data_in.red   = data_in_stage.val;
            data_in.green = data_in_stage.t;
            data_in.blue  = data_in_stage.p;
         end
         SECTOR_YELLOW_GREEN: begin
            data_in.red   = data_in_stage.q;
            data_in.green = data_in_stage.val;
            data_in.blue  = data_in_stage.p;
         end
         SECTOR_GREEN_CYAN: begin
            data_in.red   = data_in_stage.p;
            data_in.green = data_in_stage.val;
            data_in.blue  = data_in_stage.t;
         end
         SECTOR_CYAN_BLUE: begin
            data_in.red   = data_in_stage.p;
            data_in.green = data_in_stage.q;
            data_in.blue  = data_in_stage.val;
         end
         SECTOR_BLUE_MAGENTA: begin
            data_in.red   = data_in_stage.t;
            data_in.green = data_in_stage.p;
            data_in.blue  = data_in_stage.val;
         end
         default: begin
            // magenta to red; codes above five never occur
            data_in.red   = data_in_stage.val;
            data_in.green = data_in_stage.p;
            data_in.blue  = data_in_stage.q;
         end
      endcase
   end

   assign ready_out = !valid_ff || ready_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ready_out) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ready_out && valid_in) begin
         data_ff <= data_in;
      end
   end

   assign valid_out = valid_ff;
   assign data_out  = data_ff;

endmodule

`default_nettype wire

// File: rtl/core/hsv_to_rgb_converter.sv
// Top level: four-stage HSV to RGBA conversion pipeline with stream ports.
// A req transaction reaches rsp_tvalid through the prep, mult, level and mux stage registers in turn.
// Throughput: one transaction per cycle while rsp_tready is high; no state is carried between pixels.
// Each stage holds its own valid bit; a stage takes new data when it is empty or
// the stage after it moves, so a stalled rsp side fills the four stages, then drops req_tready.
// Reset (synchronous, active high) clears all valid bits; data registers are not reset.
`default_nettype none

module hsv_to_rgb_converter (
   input  wire logic        clock,
   input  wire logic        reset,
   // request stream
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [71:0] req_tdata,   // hue[15:0], saturation[32:16],
                                         // brightness[49:33], alpha_in[66:50], zero pad
   // response stream
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [71:0]      rsp_tdata    // red[16:0], green[33:17], blue[50:34],
                                         // alpha_out[67:51], zero pad
);
   import h2r_pkg::*;

   // Stage handshakes
   logic      prep_valid,  prep_ready;
   logic      mult_valid,  mult_ready;
   logic      level_valid, level_ready;
   logic      mux_ready;
   prep_type  prep_data;
   mult_type  mult_data;
   level_type level_data;
   rgba_type  rgba_data;

   // Stage 1: clamp s and v, hue * 6 -> sector and fraction
   h2r_prep u_prep (
      .clock      (clock),
      .reset      (reset),
      .valid_in   (req_tvalid),
      .ready_out  (req_tready),
      .hue        (req_tdata[15:0]),
      .saturation (req_tdata[32:16]),
      .brightness (req_tdata[49:33]),
      .alpha_in   (req_tdata[66:50]),
      .valid_out  (prep_valid),
      .ready_in   (prep_ready),
      .data_out   (prep_data)
   );

   // Stage 2: s*f, s*(1-f), p
   h2r_mult u_mult (
      .clock         (clock),
      .reset         (reset),
      .valid_in      (prep_valid),
      .ready_out     (prep_ready),
      .data_in_stage (prep_data),
      .valid_out     (mult_valid),
      .ready_in      (mult_ready),
      .data_out      (mult_data)
   );

   // Stage 3: q, t
   h2r_level u_level (
      .clock         (clock),
      .reset         (reset),
      .valid_in      (mult_valid),
      .ready_out     (mult_ready),
      .data_in_stage (mult_data),
      .valid_out     (level_valid),
      .ready_in      (level_ready),
      .data_out      (level_data)
   );

   // Stage 4: sector routing. Zero saturation needs no special path:
   // then p = q = t = v and every sector gives grey.
   h2r_mux u_mux (
      .clock         (clock),
      .reset         (reset),
      .valid_in      (level_valid),
      .ready_out     (mux_ready),
      .data_in_stage (level_data),
      .valid_out     (rsp_tvalid),
      .ready_in      (rsp_tready),
      .data_out      (rgba_data)
   );

   assign level_ready = mux_ready;
   assign rsp_tdata   = {4'b0000, rgba_data};

   // ---------------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------------

   // Derived levels never exceed the clamped value channel
   assert property (@(posedge clock) disable iff (reset)
      level_valid |-> (level_data.p <= level_data.val) && (level_data.q <= level_data.val)
                      && (level_data.t <= level_data.val))
      else $error("level above value channel");

   // A stage blocked by its successor keeps its transaction
   assert property (@(posedge clock) disable iff (reset)
      (mult_valid && !mult_ready) |=> mult_valid && $stable(mult_data))
      else $error("stalled multiplier stage lost its transaction");

   // Color channels stay within Q1.16 one
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rgba_data.red <= ONE_Q16) && (rgba_data.green <= ONE_Q16)
                     && (rgba_data.blue <= ONE_Q16))
      else $error("color channel above one");

endmodule

`default_nettype wire
